[rtl/core/pci_pkg.sv]
// Package for the path contour iterator: verb codes, phase codes, result type.
// No dependencies.
`timescale 1ns / 1ps
package pci_pkg;
    localparam logic [2:0] VERB_MOVE  = 3'd0;
    localparam logic [2:0] VERB_LINE  = 3'd1;
    localparam logic [2:0] VERB_QUAD  = 3'd2;
    localparam logic [2:0] VERB_CONIC = 3'd3;
    localparam logic [2:0] VERB_CUBIC = 3'd4;
    localparam logic [2:0] VERB_CLOSE = 3'd5;
    localparam logic [2:0] VERB_DONE  = 3'd6;
    // Unused command code: drop the item, emit nothing
    localparam logic [2:0] OP_RESERVED = 3'd7;

    localparam logic [1:0] PH_EMPTY = 2'd0;
    localparam logic [1:0] PH_MOVE  = 2'd1;
    localparam logic [1:0] PH_PRIM  = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic        final_verb;
        logic [31:0] in0_x;
        logic [31:0] in0_y;
        logic [31:0] in1_x;
        logic [31:0] in1_y;
        logic [31:0] in2_x;
        logic [31:0] in2_y;
        logic [31:0] in_weight;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  seg_verb;
        logic [31:0] out0_x;
        logic [31:0] out0_y;
        logic [31:0] out1_x;
        logic [31:0] out1_y;
        logic [31:0] out2_x;
        logic [31:0] out2_y;
        logic [31:0] out3_x;
        logic [31:0] out3_y;
        logic [31:0] out_weight;
        logic        is_close_line;
        logic        last_of_run;
    } t_seg;

    function automatic logic f_is_nan(input logic [31:0] b);
        return (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    endfunction

    // Float equality: NaN equals nothing, -0 equals +0.
    function automatic logic f_feq(input logic [31:0] a, input logic [31:0] b);
        if (f_is_nan(a) || f_is_nan(b))
            return 1'b0;
        return (a == b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0));
    endfunction
endpackage

[rtl/core/pci_if.sv]
// Valid/ready channel interfaces for commands and segments.
// Depends on pci_pkg.
`timescale 1ns / 1ps
interface pci_cmd_if import pci_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pci_seg_if import pci_pkg::*; ();
    logic valid;
    logic ready;
    t_seg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/path_contour_iterator.sv]
// Path contour iterator top level: command in, segments out, with auto close.
// Depends on pci_pkg and the channel interfaces in pci_if.sv.
`timescale 1ns / 1ps
//
// Usage:
//   i_cmd carries one path command per item (move, line, quad, conic, cubic,
//   close, end). o_seg carries the resulting segments, start points filled in.
//   i_cfg_we / i_cfg_wdata write force_close; write only while idle.
//   A command is taken into an input register and decoded there into up to
//   three result items (closing line, close, then move or done); a reserved
//   command yields none. One item leaves o_seg per cycle while o_seg is
//   ready; each inserted result is one more item. Results move from the
//   input register into the output register once it is free. The input register
//   refills in the same cycle its last result moves to the output register,
//   so plain primitives stream at one per cycle when o_seg does not stall.
//   A stalled receiver holds the output register; the input register then
//   holds too and i_cmd.ready drops. Contour state is updated once, when the
//   last result of a command enters the output register.
//   Reset (synchronous, active low) empties both registers and clears the
//   contour state and force_close.
//
module path_contour_iterator
    import pci_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    pci_cmd_if.sink      i_cmd,
    pci_seg_if.source    o_seg
);
    logic        r_force;
    logic        r_in_vld, n_in_vld;
    t_cmd        r_in;
    logic [1:0]  r_idx, n_idx;     // index of the next result of r_in
    logic        r_out_vld, n_out_vld;
    t_seg        r_out, n_out;
    logic [31:0] r_sx, r_sy, r_px, r_py, r_qx, r_qy;
    logic [31:0] n_sx, n_sy, n_px, n_py, n_qx, n_qy;
    logic [1:0]  r_phase, n_phase;
    logic        r_pend, r_clf;
    logic        n_pend, n_clf;

    // Decoded result list for the held command
    t_seg        res [3];
    logic [1:0]  n_res;
    logic        do_close, line_ins, ign;
    logic [1:0]  k0;
    logic        out_free, emit, last_emit, take;
    logic [31:0] bx, by;

    assign out_free = !r_out_vld || o_seg.ready;
    assign ign      = (r_in.op == OP_RESERVED);

    always_comb begin
        t_seg z;
        z = '0;
        for (int i = 0; i < 3; i++) res[i] = z;
        do_close = 1'b0;
        unique case (r_in.op)
            VERB_MOVE:  do_close = r_pend;
            VERB_CLOSE: do_close = 1'b1;
            VERB_DONE:  do_close = r_pend && (r_phase == PH_PRIM);
            default:    do_close = 1'b0;
        endcase
        line_ins = do_close && !(f_feq(r_px, r_sx) && f_feq(r_py, r_sy))
            && !(f_is_nan(r_px) || f_is_nan(r_py) || f_is_nan(r_sx) || f_is_nan(r_sy));
        k0 = 2'd0;
        if (line_ins) begin
            res[0].seg_verb = VERB_LINE;
            res[0].out0_x = r_px; res[0].out0_y = r_py;
            res[0].out1_x = r_sx; res[0].out1_y = r_sy;
            res[0].is_close_line = 1'b1;
            k0 = 2'd1;
        end
        if (do_close) begin
            res[k0].seg_verb = VERB_CLOSE;
            res[k0].out0_x = r_sx; res[k0].out0_y = r_sy;
            k0 = k0 + 2'd1;
        end
        bx = (r_phase == PH_MOVE) ? r_sx : r_qx;
        by = (r_phase == PH_MOVE) ? r_sy : r_qy;
        z.out0_x = bx; z.out0_y = by;
        z.out1_x = r_in.in0_x; z.out1_y = r_in.in0_y;
        unique case (r_in.op)
            VERB_MOVE: begin
                z = '0;
                if (r_in.final_verb) begin
                    z.seg_verb = VERB_DONE;
                end else begin
                    z.seg_verb = VERB_MOVE;
                    z.out0_x = r_in.in0_x; z.out0_y = r_in.in0_y;
                end
            end
            VERB_LINE: z.seg_verb = VERB_LINE;
            VERB_QUAD, VERB_CONIC: begin
                z.seg_verb = r_in.op;
                z.out2_x = r_in.in1_x; z.out2_y = r_in.in1_y;
                if (r_in.op == VERB_CONIC) z.out_weight = r_in.in_weight;
            end
            VERB_CUBIC: begin
                z.seg_verb = VERB_CUBIC;
                z.out2_x = r_in.in1_x; z.out2_y = r_in.in1_y;
                z.out3_x = r_in.in2_x; z.out3_y = r_in.in2_y;
            end
            VERB_DONE: z = '0;
            default:   z = '0;
        endcase
        if (r_in.op == VERB_DONE) z.seg_verb = VERB_DONE;
        if (r_in.op != VERB_CLOSE && !ign) begin
            res[k0] = z;
            k0 = k0 + 2'd1;
        end
        n_res = k0;
    end

    assign emit      = r_in_vld && !ign && out_free;
    assign last_emit = emit && (r_idx == n_res - 2'd1);
    assign take      = !r_in_vld || last_emit || ign;
    assign i_cmd.ready = take;

    always_comb begin
        n_in_vld = r_in_vld;
        n_idx    = r_idx;
        if (take) begin
            n_in_vld = i_cmd.valid;
            n_idx    = 2'd0;
        end else if (emit) begin
            n_idx = r_idx + 2'd1;
        end
        n_out_vld = r_out_vld;
        if (emit) n_out_vld = 1'b1;
        else if (o_seg.ready) n_out_vld = 1'b0;
        n_out = res[r_idx];
        n_out.last_of_run = (r_idx == n_res - 2'd1);
    end

    // Next contour state, committed once with the last result of a command
    always_comb begin
        n_sx = r_sx; n_sy = r_sy;
        n_px = r_px; n_py = r_py;
        n_qx = r_qx; n_qy = r_qy;
        n_phase = r_phase;
        n_pend  = r_pend;
        n_clf   = r_clf;
        if (last_emit) begin
            if (line_ins) n_clf = 1'b1;
            if (do_close) begin
                n_pend = 1'b0;
                if (line_ins) begin
                    n_px = r_sx; n_py = r_sy;
                end
            end
            unique case (r_in.op)
                VERB_MOVE: if (!r_in.final_verb) begin
                    n_sx = r_in.in0_x; n_sy = r_in.in0_y;
                    n_px = r_in.in0_x; n_py = r_in.in0_y;
                    n_qx = r_in.in0_x; n_qy = r_in.in0_y;
                    n_phase = PH_MOVE;
                    n_pend  = r_force;
                end
                VERB_LINE: begin
                    if (r_phase == PH_MOVE) n_phase = PH_PRIM;
                    n_px = r_in.in0_x; n_py = r_in.in0_y;
                    n_qx = r_in.in0_x; n_qy = r_in.in0_y;
                    n_clf = 1'b0;
                end
                VERB_QUAD, VERB_CONIC: begin
                    if (r_phase == PH_MOVE) n_phase = PH_PRIM;
                    n_px = r_in.in1_x; n_py = r_in.in1_y;
                    n_qx = r_in.in1_x; n_qy = r_in.in1_y;
                end
                VERB_CUBIC: begin
                    if (r_phase == PH_MOVE) n_phase = PH_PRIM;
                    n_px = r_in.in2_x; n_py = r_in.in2_y;
                    n_qx = r_in.in2_x; n_qy = r_in.in2_y;
                end
                VERB_CLOSE: begin
                    n_phase = PH_EMPTY;
                    n_px = r_sx; n_py = r_sy;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force <= 1'b0;
            r_in_vld <= 1'b0;
            r_idx <= 2'd0;
            r_out_vld <= 1'b0;
            r_sx <= '0; r_sy <= '0; r_px <= '0; r_py <= '0; r_qx <= '0; r_qy <= '0;
            r_phase <= PH_EMPTY;
            r_pend <= 1'b0;
            r_clf <= 1'b0;
        end else begin
            if (i_cfg_we) r_force <= i_cfg_wdata;
            r_in_vld <= n_in_vld;
            r_idx <= n_idx;
            r_out_vld <= n_out_vld;
            r_sx <= n_sx; r_sy <= n_sy;
            r_px <= n_px; r_py <= n_py;
            r_qx <= n_qx; r_qy <= n_qy;
            r_phase <= n_phase;
            r_pend <= n_pend;
            r_clf <= n_clf;
            if (take && i_cmd.valid) r_in <= i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) r_out <= n_out;
    end

    assign o_seg.valid = r_out_vld;
    assign o_seg.data  = r_out;

    // Stalled output holds its item
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_seg.ready |=> r_out_vld && $stable(r_out))
        else $error("output changed under stall");
    // Result index never runs past the result count
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !ign |-> r_idx < n_res)
        else $error("result index overrun");
    // Nothing emitted while the output is blocked
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("emit into full output");
endmodule

[tb/tb_path_contour_iterator.sv]
// Testbench for path_contour_iterator: drives path commands and checks every segment item
// against a predictor of the contour state kept inside this file.
// Depends on pci_pkg, pci_if.sv and the block itself.
`timescale 1ns / 1ps
module tb_path_contour_iterator;
    import pci_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [31:0] F_QNAN = 32'h7fc00000;
    localparam logic [31:0] F_NEGZ = 32'h80000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;

    pci_cmd_if cmd_ch ();
    pci_seg_if seg_ch ();

    path_contour_iterator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_cmd      (cmd_ch.sink),
        .o_seg      (seg_ch.source)
    );

    always #10 i_clk = ~i_clk;

    // Predictor copy of the contour state and the force_close register.
    logic        pr_force;
    logic [31:0] pr_start_x, pr_start_y, pr_pen_x, pr_pen_y, pr_src_x, pr_src_y;
    logic [1:0]  pr_phase;
    logic        pr_pending;

    t_seg seg_expected[$];
    int   mismatches = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_recv = 1'b0;

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        seg_ch.ready = 1'b0;
    end

    // Float test helpers written here: NaN matches nothing, the two zeros match.
    function automatic bit fp_nan(logic [31:0] b);
        return b[30:23] == 8'hff && b[22:0] != 0;
    endfunction

    function automatic bit fp_same(logic [31:0] a, logic [31:0] b);
        if (fp_nan(a) || fp_nan(b)) return 1'b0;
        return a == b || (a[30:0] == 0 && b[30:0] == 0);
    endfunction

    task automatic push_seg(logic [2:0] verb, logic [31:0] p[8], logic [31:0] w, bit cl);
        t_seg s;
        s = '0;
        s.seg_verb = verb;
        {s.out0_x, s.out0_y, s.out1_x, s.out1_y} = {p[0], p[1], p[2], p[3]};
        {s.out2_x, s.out2_y, s.out3_x, s.out3_y} = {p[4], p[5], p[6], p[7]};
        s.out_weight = w;
        s.is_close_line = cl;
        seg_expected.push_back(s);
    endtask

    // Add the closing line where the pen is off the start and nothing is NaN, then a close.
    task automatic close_contour_predict();
        logic [31:0] p[8];
        p = '{default: 0};
        if (!(fp_same(pr_pen_x, pr_start_x) && fp_same(pr_pen_y, pr_start_y)) &&
            !(fp_nan(pr_pen_x) || fp_nan(pr_pen_y) ||
              fp_nan(pr_start_x) || fp_nan(pr_start_y))) begin
            p[0] = pr_pen_x; p[1] = pr_pen_y; p[2] = pr_start_x; p[3] = pr_start_y;
            pr_pen_x = pr_start_x;
            pr_pen_y = pr_start_y;
            push_seg(VERB_LINE, p, 32'd0, 1'b1);
            p = '{default: 0};
        end
        p[0] = pr_start_x; p[1] = pr_start_y;
        push_seg(VERB_CLOSE, p, 32'd0, 1'b0);
        pr_pending = 1'b0;
    endtask

    // Segment start: contour start right after a move, else the prior source point.
    task automatic seg_start_predict(ref logic [31:0] p[8]);
        if (pr_phase == PH_MOVE) begin
            pr_phase = PH_PRIM;
            p[0] = pr_start_x; p[1] = pr_start_y;
        end else begin
            p[0] = pr_src_x; p[1] = pr_src_y;
        end
    endtask

    task automatic predict_segments(t_cmd c);
        logic [31:0] p[8];
        int n0;
        p = '{default: 0};
        n0 = seg_expected.size();
        case (c.op)
            VERB_MOVE: begin
                if (pr_pending) close_contour_predict();
                if (c.final_verb) begin
                    push_seg(VERB_DONE, p, 32'd0, 1'b0);
                end else begin
                    pr_start_x = c.in0_x; pr_start_y = c.in0_y;
                    pr_pen_x = c.in0_x;   pr_pen_y = c.in0_y;
                    pr_src_x = c.in0_x;   pr_src_y = c.in0_y;
                    pr_phase = PH_MOVE;
                    pr_pending = pr_force;
                    p[0] = c.in0_x; p[1] = c.in0_y;
                    push_seg(VERB_MOVE, p, 32'd0, 1'b0);
                end
            end
            VERB_LINE: begin
                seg_start_predict(p);
                p[2] = c.in0_x; p[3] = c.in0_y;
                pr_pen_x = c.in0_x; pr_src_x = c.in0_x;
                pr_pen_y = c.in0_y; pr_src_y = c.in0_y;
                push_seg(VERB_LINE, p, 32'd0, 1'b0);
            end
            VERB_QUAD, VERB_CONIC: begin
                seg_start_predict(p);
                p[2] = c.in0_x; p[3] = c.in0_y; p[4] = c.in1_x; p[5] = c.in1_y;
                pr_pen_x = c.in1_x; pr_src_x = c.in1_x;
                pr_pen_y = c.in1_y; pr_src_y = c.in1_y;
                push_seg(c.op, p, (c.op == VERB_CONIC) ? c.in_weight : 32'd0, 1'b0);
            end
            VERB_CUBIC: begin
                seg_start_predict(p);
                p[2] = c.in0_x; p[3] = c.in0_y; p[4] = c.in1_x; p[5] = c.in1_y;
                p[6] = c.in2_x; p[7] = c.in2_y;
                pr_pen_x = c.in2_x; pr_src_x = c.in2_x;
                pr_pen_y = c.in2_y; pr_src_y = c.in2_y;
                push_seg(VERB_CUBIC, p, 32'd0, 1'b0);
            end
            VERB_CLOSE: begin
                close_contour_predict();
                pr_phase = PH_EMPTY;
                pr_pen_x = pr_start_x;
                pr_pen_y = pr_start_y;
            end
            VERB_DONE: begin
                if (pr_pending && pr_phase == PH_PRIM) close_contour_predict();
                push_seg(VERB_DONE, p, 32'd0, 1'b0);
            end
            default: ;
        endcase
        // Mark the final item this command produced.
        if (seg_expected.size() > n0)
            seg_expected[seg_expected.size() - 1].last_of_run = 1'b1;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("MISMATCH @%0t %s: got %h want %h", $time, what, got, want);
    endtask

    // Offer one command, hold it until taken, then predict its segments.
    // Valid stays high after the handshake; the next idle cycle or drain drops it.
    task automatic send_cmd(t_cmd c);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do @(posedge i_clk); while (!cmd_ch.ready);
        predict_segments(c);
    endtask

    function automatic t_cmd make_cmd(logic [2:0] op, bit fin, logic [31:0] ax,
                                      logic [31:0] ay);
        t_cmd c;
        c.op = op; c.final_verb = fin;
        c.in0_x = ax; c.in0_y = ay;
        c.in1_x = $urandom; c.in1_y = $urandom;
        c.in2_x = $urandom; c.in2_y = $urandom;
        c.in_weight = $urandom;
        return c;
    endfunction

    // Coordinates drawn from a tiny pool in four cases of ten so points often coincide,
    // with zeros of both signs, NaN and full random patterns mixed in.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0: return F_QNAN;
            1: return F_NEGZ;
            2: return 32'd0;
            3, 4: return $urandom;
            5: return 32'hffffffff;
            default: return 32'h3f800000 + ($urandom_range(3) << 23);
        endcase
    endfunction

    // Receiver: random stalls, or a long hold-off while hold_recv is set.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            seg_ch.ready <= 1'b0;
        end else begin
            seg_ch.ready <= !hold_recv && !($urandom_range(99) < recv_idle_pct);
        end
    end

    // Check each taken segment item against the oldest expectation.
    always @(posedge i_clk) begin
        t_seg got, want;
        if (i_rst_n && seg_ch.valid && seg_ch.ready) begin
            got = seg_ch.data;
            if (seg_expected.size() == 0) begin
                report_mismatch("unexpected item", 32'(got.seg_verb), 32'd0);
            end else begin
                want = seg_expected.pop_front();
                if (got.seg_verb != want.seg_verb)
                    report_mismatch("seg_verb", 32'(got.seg_verb), 32'(want.seg_verb));
                if (got.out0_x != want.out0_x) report_mismatch("out0_x", got.out0_x, want.out0_x);
                if (got.out0_y != want.out0_y) report_mismatch("out0_y", got.out0_y, want.out0_y);
                if (got.out1_x != want.out1_x) report_mismatch("out1_x", got.out1_x, want.out1_x);
                if (got.out1_y != want.out1_y) report_mismatch("out1_y", got.out1_y, want.out1_y);
                if (got.out2_x != want.out2_x) report_mismatch("out2_x", got.out2_x, want.out2_x);
                if (got.out2_y != want.out2_y) report_mismatch("out2_y", got.out2_y, want.out2_y);
                if (got.out3_x != want.out3_x) report_mismatch("out3_x", got.out3_x, want.out3_x);
                if (got.out3_y != want.out3_y) report_mismatch("out3_y", got.out3_y, want.out3_y);
                if (got.out_weight != want.out_weight)
                    report_mismatch("out_weight", got.out_weight, want.out_weight);
                if (got.is_close_line != want.is_close_line)
                    report_mismatch("is_close_line", 32'(got.is_close_line),
                                    32'(want.is_close_line));
                if (got.last_of_run != want.last_of_run)
                    report_mismatch("last_of_run", 32'(got.last_of_run),
                                    32'(want.last_of_run));
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("path_contour_iterator verification failed");
            $finish;
        end
    end

    // Drop valid, wait until every expected item has come, then let the block settle.
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (seg_expected.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write force_close only while the block is idle.
    task automatic write_force_close(bit v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pr_force = v;
    endtask

    // Directed: every op, the extreme field values and each special case.
    task automatic test_directed();
        write_force_close(1'b0);
        // Primitive with no move: starts at the prior source point.
        send_cmd(make_cmd(VERB_LINE, 1'b0, 32'hffffffff, 32'h00000000));
        send_cmd(make_cmd(VERB_QUAD, 1'b0, 32'h3f800000, 32'h40000000));
        send_cmd(make_cmd(VERB_DONE, 1'b0, 32'd0, 32'd0));
        send_cmd(make_cmd(VERB_MOVE, 1'b0, 32'h3f800000, 32'h3f800000));
        send_cmd(make_cmd(VERB_CONIC, 1'b0, 32'h40000000, 32'h40400000));
        send_cmd(make_cmd(VERB_CUBIC, 1'b1, 32'hffffffff, 32'hffffffff));
        send_cmd(make_cmd(VERB_CLOSE, 1'b0, 32'd0, 32'd0));
        // Close where the pen already sits at the start, using -0 against +0.
        send_cmd(make_cmd(VERB_MOVE, 1'b0, 32'd0, F_NEGZ));
        send_cmd(make_cmd(VERB_LINE, 1'b0, F_NEGZ, 32'd0));
        send_cmd(make_cmd(VERB_CLOSE, 1'b0, 32'd0, 32'd0));
        // NaN at close: the closing line is skipped.
        send_cmd(make_cmd(VERB_MOVE, 1'b0, F_QNAN, 32'h3f800000));
        send_cmd(make_cmd(VERB_LINE, 1'b0, 32'h40000000, 32'h40000000));
        send_cmd(make_cmd(VERB_CLOSE, 1'b0, 32'd0, 32'd0));
        send_cmd(make_cmd(OP_RESERVED, 1'b1, 32'hffffffff, 32'hffffffff));
        write_force_close(1'b1);
        // Move while a close is pending, then a final move giving done.
        send_cmd(make_cmd(VERB_MOVE, 1'b0, 32'h3f800000, 32'h3f800000));
        send_cmd(make_cmd(VERB_LINE, 1'b0, 32'h40000000, 32'h3f800000));
        send_cmd(make_cmd(VERB_MOVE, 1'b0, 32'h40400000, 32'h40400000));
        send_cmd(make_cmd(VERB_CUBIC, 1'b0, 32'h3f800000, 32'h3f800000));
        send_cmd(make_cmd(VERB_MOVE, 1'b1, 32'hffffffff, 32'hffffffff));
        // End of path with a close armed after a primitive.
        send_cmd(make_cmd(VERB_MOVE, 1'b0, 32'h40800000, 32'h40800000));
        send_cmd(make_cmd(VERB_QUAD, 1'b0, 32'h3f800000, 32'h3f800000));
        send_cmd(make_cmd(VERB_DONE, 1'b1, 32'd0, 32'd0));
        // End of path with a close armed right after the move: no close.
        send_cmd(make_cmd(VERB_MOVE, 1'b0, 32'h40800000, 32'h3f800000));
        send_cmd(make_cmd(VERB_DONE, 1'b0, 32'd0, 32'd0));
    endtask

    // Random: mostly well-formed contours with random content, some noise.
    task automatic test_random(int n_cmds);
        t_cmd c;
        int sent;
        int len;
        sent = 0;
        while (sent < n_cmds) begin
            if ($urandom_range(9) < 8) begin
                send_cmd(make_cmd(VERB_MOVE, 1'b0, rand_coord(), rand_coord()));
                len = $urandom_range(1, 5);
                repeat (len) begin
                    c = make_cmd(3'($urandom_range(VERB_LINE, VERB_CUBIC)),
                                 1'($urandom_range(1)), rand_coord(), rand_coord());
                    c.in1_x = rand_coord(); c.in1_y = rand_coord();
                    c.in2_x = rand_coord(); c.in2_y = rand_coord();
                    send_cmd(c);
                end
                sent += len + 1;
                case ($urandom_range(3))
                    0: begin
                        send_cmd(make_cmd(VERB_CLOSE, 1'b0, $urandom, $urandom));
                        sent++;
                    end
                    1: begin
                        send_cmd(make_cmd(VERB_DONE, 1'($urandom_range(1)), $urandom,
                                          $urandom));
                        sent++;
                    end
                    2: begin
                        send_cmd(make_cmd(VERB_MOVE, 1'b1, $urandom, $urandom));
                        sent++;
                    end
                    default: ;
                endcase
            end else begin
                c = make_cmd(3'($urandom_range(7)), 1'($urandom_range(1)), rand_coord(),
                             rand_coord());
                send_cmd(c);
                sent++;
            end
        end
    endtask

    // Hold the receiver off while commands keep coming, so the input stalls.
    task automatic test_backpressure();
        hold_recv = 1'b1;
        fork
            begin
                repeat (60) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            test_random(12);
        join
        // Pause the sender until the block has drained.
        drain();
        test_random(8);
    endtask

    initial begin
        pr_force = 1'b0;
        pr_start_x = 0; pr_start_y = 0; pr_pen_x = 0; pr_pen_y = 0;
        pr_src_x = 0; pr_src_y = 0; pr_phase = PH_EMPTY; pr_pending = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        send_idle_pct = 23; recv_idle_pct = 71;
        test_random(140);
        write_force_close(1'b0);
        send_idle_pct = 71; recv_idle_pct = 23;
        test_random(140);
        write_force_close(1'b1);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(140);
        test_backpressure();

        drain();
        if (mismatches == 0) begin
            $display("path_contour_iterator verification clean");
        end else begin
            $display("path_contour_iterator verification failed");
        end
        $finish;
    end
endmodule
